@@ rtl/core/u16u8_pkg.sv @@
// Package for the UTF-16 to UTF-8 transcoder.
// Holds the run entry type, error codes and encoding constants.
// No dependencies.
`default_nettype none

package u16u8_pkg;

    // Error code carried on every result of a run
    typedef enum logic [1:0] {
        ERR_NONE            = 2'd0,
        ERR_HIGH_AFTER_HIGH = 2'd1,
        ERR_LOW_NO_HIGH     = 2'd2,
        ERR_HIGH_DROPPED    = 2'd3
    } unit_err_t;

    // One decoded code unit, ready for the byte serializer
    typedef struct packed {
        logic [3:0][7:0] bytes;      // encoded bytes, index 0 goes out first
        logic [1:0]      last_idx;   // index of the final byte of the run
        logic            has_bytes;  // 0: empty run, one result with no byte
        unit_err_t       err;
        logic            dangling;
    } run_entry_t;

    // Byte order marks
    localparam logic [7:0] BOM_FE = 8'hFE;
    localparam logic [7:0] BOM_FF = 8'hFF;

    // Surrogate decoding
    localparam logic [15:0] SURR_MASK    = 16'hF800;
    localparam logic [15:0] SURR_BASE    = 16'hD800;
    localparam logic [15:0] SURR_LOW_BIT = 16'h0400;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    // UTF-8 range limits and prefixes
    localparam logic [20:0] LIMIT_1B    = 21'h00080;
    localparam logic [20:0] LIMIT_2B    = 21'h00800;
    localparam logic [20:0] LIMIT_3B    = 21'h10000;
    localparam logic [7:0]  CONT_PREFIX = 8'h80;
    localparam logic [7:0]  LEAD_2B     = 8'hC0;
    localparam logic [7:0]  LEAD_3B     = 8'hE0;
    localparam logic [7:0]  LEAD_4B     = 8'hF0;

endpackage

`default_nettype wire

@@ rtl/core/utf16_to_utf8_transcoder_top.sv @@
// The first UTF-8 byte passes the run entry queue and then the serializer
// register before it is presented. Throughput: the byte-wide output
// serializer gives one output byte per cycle while m_axis_tready is high;
// a code unit gives 1 to 4 bytes, its UTF-8 length (one result with no byte
// for an empty run). A run entry queue decouples input from output.
// Reset (rst_n, async, active low): big endian, no held surrogate, queue empty.
`default_nettype none

module utf16_to_utf8_transcoder_top
    import u16u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration: initial_big_endian
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [7:0] first_byte, [15:8] second_byte
    input  wire logic        s_axis_tlast,   // end_of_string
    // output stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] utf8_byte
    output logic             m_axis_tlast,   // last_of_run
    output logic [3:0]       m_axis_tuser    // [0] byte_valid, [2:1] unit_error,
                                             // [3] dangling_at_end
);

    run_entry_t front_entry;
    run_entry_t q_data;
    logic       q_full;
    logic       q_valid;
    logic       q_pop;
    logic       unit_accept;

    assign s_axis_tready = !q_full;
    assign unit_accept   = s_axis_tvalid && s_axis_tready;

    u16u8_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .unit_accept   (unit_accept),
        .first_byte    (s_axis_tdata[7:0]),
        .second_byte   (s_axis_tdata[15:8]),
        .end_of_string (s_axis_tlast),
        .entry         (front_entry)
    );

    u16u8_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (unit_accept),
        .wr_data  (front_entry),
        .full     (q_full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_data  (q_data)
    );

    u16u8_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

@@ rtl/core/u16u8_front.sv @@
// Front end: takes code units, tracks byte order and held surrogate,
// encodes the code point into a run entry. Depends on u16u8_pkg.
`default_nettype none

module u16u8_front
    import u16u8_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic       cfg_wr_data,
    input  wire logic       unit_accept,
    input  wire logic [7:0] first_byte,
    input  wire logic [7:0] second_byte,
    input  wire logic       end_of_string,
    output run_entry_t      entry
);

    logic        init_big_reg,   init_big_next;
    logic        order_big_reg,  order_big_next;
    logic [9:0]  pend_bits_reg,  pend_bits_next;
    logic        pend_valid_reg, pend_valid_next;

    logic        order_now;
    logic [15:0] unit;
    logic [20:0] cp;
    unit_err_t   err;
    logic        pend_after;

    // Byte order for this unit and unit assembly
    always_comb
    begin
        order_now = order_big_reg;
        if (first_byte == BOM_FE && second_byte == BOM_FF)
        begin
            order_now = 1'b1;
        end
        else if (first_byte == BOM_FF && second_byte == BOM_FE)
        begin
            order_now = 1'b0;
        end
        unit = order_now ? {first_byte, second_byte} : {second_byte, first_byte};
    end

    // Surrogate pairing and state update
    always_comb
    begin
        cp              = '0;
        err             = ERR_NONE;
        pend_bits_next  = pend_bits_reg;
        pend_valid_next = pend_valid_reg;
        init_big_next   = init_big_reg;
        order_big_next  = order_big_reg;

        if ((unit & SURR_MASK) == SURR_BASE)
        begin
            if ((unit & SURR_LOW_BIT) == 16'h0000)
            begin
                if (pend_valid_reg)
                begin
                    err = ERR_HIGH_AFTER_HIGH;
                end
                pend_bits_next  = unit[9:0];
                pend_valid_next = 1'b1;
            end
            else
            begin
                if (!pend_valid_reg)
                begin
                    err = ERR_LOW_NO_HIGH;
                end
                // held bits are zero when nothing is held
                cp              = SUPP_BASE + {1'b0, pend_bits_reg, unit[9:0]};
                pend_bits_next  = '0;
                pend_valid_next = 1'b0;
            end
        end
        else
        begin
            if (pend_valid_reg)
            begin
                err = ERR_HIGH_DROPPED;
            end
            pend_bits_next  = '0;
            pend_valid_next = 1'b0;
            cp              = {5'd0, unit};
        end

        pend_after = pend_valid_next;
        order_big_next = order_now;
        if (end_of_string)
        begin
            pend_bits_next  = '0;
            pend_valid_next = 1'b0;
            order_big_next  = init_big_reg;
        end

        // without a unit transfer the unit state holds
        if (!unit_accept)
        begin
            pend_bits_next  = pend_bits_reg;
            pend_valid_next = pend_valid_reg;
            order_big_next  = order_big_reg;
        end

        // a register write also reloads the byte order
        if (cfg_wr_en)
        begin
            init_big_next  = cfg_wr_data;
            order_big_next = cfg_wr_data;
        end
    end

    // UTF-8 encoding of the code point
    always_comb
    begin
        entry           = '0;
        entry.err       = err;
        entry.dangling  = end_of_string & pend_after;
        priority if (cp == 21'd0)
        begin
            entry.has_bytes = 1'b0;
        end
        else if (cp < LIMIT_1B)
        begin
            entry.has_bytes = 1'b1;
            entry.bytes[0]  = cp[7:0];
            entry.last_idx  = 2'd0;
        end
        else if (cp < LIMIT_2B)
        begin
            entry.has_bytes = 1'b1;
            entry.bytes[0]  = LEAD_2B | {3'd0, cp[10:6]};
            entry.bytes[1]  = CONT_PREFIX | {2'd0, cp[5:0]};
            entry.last_idx  = 2'd1;
        end
        else if (cp < LIMIT_3B)
        begin
            entry.has_bytes = 1'b1;
            entry.bytes[0]  = LEAD_3B | {4'd0, cp[15:12]};
            entry.bytes[1]  = CONT_PREFIX | {2'd0, cp[11:6]};
            entry.bytes[2]  = CONT_PREFIX | {2'd0, cp[5:0]};
            entry.last_idx  = 2'd2;
        end
        else
        begin
            entry.has_bytes = 1'b1;
            entry.bytes[0]  = LEAD_4B | {5'd0, cp[20:18]};
            entry.bytes[1]  = CONT_PREFIX | {2'd0, cp[17:12]};
            entry.bytes[2]  = CONT_PREFIX | {2'd0, cp[11:6]};
            entry.bytes[3]  = CONT_PREFIX | {2'd0, cp[5:0]};
            entry.last_idx  = 2'd3;
        end
    end

    // State registers; updates only on an accepted unit or a config write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_big_reg   <= 1'b1;
            order_big_reg  <= 1'b1;
            pend_bits_reg  <= '0;
            pend_valid_reg <= 1'b0;
        end
        else if (unit_accept || cfg_wr_en)
        begin
            init_big_reg   <= init_big_next;
            order_big_reg  <= order_big_next;
            pend_bits_reg  <= pend_bits_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/u16u8_queue.sv @@
// Small flop-based queue of run entries between front and back end.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int DEPTH = 2   // 2 to 8 entries
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  run_entry_t wr_data,
    output logic      full,
    input  wire logic rd_en,
    output logic      rd_valid,
    output run_entry_t rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    run_entry_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             do_wr, do_rd;

    assign full     = (cnt_reg == CNT_FULL);
    assign rd_valid = (cnt_reg != '0);
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + CNT_ONE;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Payload storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/u16u8_back.sv @@
// Back end: serializes one run entry into UTF-8 byte transfers.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_back
    import u16u8_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    input  run_entry_t q_data,
    output logic       q_pop,
    output logic       m_axis_tvalid,
    input  wire logic  m_axis_tready,
    output logic [7:0] m_axis_tdata,
    output logic       m_axis_tlast,
    output logic [3:0] m_axis_tuser
);

    run_entry_t entry_reg, entry_next;
    logic [1:0] idx_reg,   idx_next;
    logic       valid_reg, valid_next;
    logic       at_last;

    assign at_last = (idx_reg == entry_reg.last_idx);
    assign q_pop   = q_valid && (!valid_reg || (m_axis_tready && at_last));

    // Advance through the bytes of the current run
    always_comb
    begin
        entry_next = entry_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (q_pop)
        begin
            entry_next = q_data;
            idx_next   = 2'd0;
            valid_next = 1'b1;
        end
        else if (valid_reg && m_axis_tready)
        begin
            if (at_last)
            begin
                valid_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // Output stage driven from registers
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = entry_reg.bytes[idx_reg];
    assign m_axis_tlast  = at_last;
    assign m_axis_tuser  = {entry_reg.dangling, entry_reg.err, entry_reg.has_bytes};

endmodule

`default_nettype wire

@@ rtl/core/u16u8_checker.sv @@
// Port-level checks for the transcoder top level, bound to it below.
// No package dependency.
`default_nettype none

module u16u8_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tlast,
    input wire logic [3:0]  m_axis_tuser
);

    // A stalled output transfer holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    // An empty run is a single result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && (m_axis_tdata == 8'h00))
        else $error("empty result not alone or carries data");

    // Within a run the next byte follows at once with the same flags
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
            m_axis_tvalid && m_axis_tuser[0] && (m_axis_tuser[3:1] == $past(m_axis_tuser[3:1])))
        else $error("run broken or flags changed within run");

    // A byte that continues a run is a UTF-8 continuation byte
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tdata[7:6] == 2'b10)
        else $error("non-continuation byte inside a run");

endmodule

bind utf16_to_utf8_transcoder_top u16u8_checker u_u16u8_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

@@ sim/testbench.sv @@
// Self-checking testbench for utf16_to_utf8_transcoder_top.
// Drives UTF-16 code units, predicts the UTF-8 bytes and flags, checks every transfer.
// Depends on u16u8_pkg and the transcoder RTL.
`timescale 1ns / 100ps

module testbench;
    import u16u8_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 6;
    localparam int RANDOM_UNITS   = 40;

    // One expected UTF-8 output transfer
    typedef struct packed {
        logic [7:0] utf8_byte;
        logic       byte_valid;
        logic       last_of_run;
        unit_err_t  unit_error;
        logic       dangling_at_end;
    } utf8_result_t;

    // Scoreboard: mirrors the transcoder state and holds the expected byte stream
    class utf8_scoreboard;
        bit           init_big;
        bit           order_big;
        bit           held_valid;
        bit [9:0]     held_bits;
        utf8_result_t pending_bytes[$];
        int           errors;
        int           n_results;
        int           n_empty;
        int           n_pairs;
        int           n_dangling;
        int           err_seen[4];

        function new();
            init_big   = 1'b1;
            order_big  = 1'b1;
            held_valid = 1'b0;
            held_bits  = '0;
            errors     = 0;
            n_results  = 0;
            n_empty    = 0;
            n_pairs    = 0;
            n_dangling = 0;
            foreach (err_seen[i]) err_seen[i] = 0;
        endfunction

        // Register write also reloads the live byte order
        function void load_config(bit big);
            init_big  = big;
            order_big = big;
        endfunction

        function int outstanding();
            return pending_bytes.size();
        endfunction

        // Accepted input transfer: decode the unit and queue its UTF-8 run
        function void note_unit(logic [7:0] b0, logic [7:0] b1, logic eos);
            logic [15:0]  unit;
            logic [20:0]  cp;
            unit_err_t    err;
            logic         dang;
            logic [7:0]   enc[4];
            int           n;
            int           k;
            utf8_result_t r;

            if (b0 == BOM_FE && b1 == BOM_FF)
                order_big = 1'b1;
            if (b0 == BOM_FF && b1 == BOM_FE)
                order_big = 1'b0;
            unit = order_big ? {b0, b1} : {b1, b0};
            cp   = '0;
            err  = ERR_NONE;
            dang = 1'b0;

            // Surrogate pairing
            if ((unit & SURR_MASK) == SURR_BASE)
            begin
                if ((unit & SURR_LOW_BIT) == 16'd0)
                begin
                    if (held_valid)
                        err = ERR_HIGH_AFTER_HIGH;
                    held_bits  = unit[9:0];
                    held_valid = 1'b1;
                end
                else
                begin
                    if (!held_valid)
                        err = ERR_LOW_NO_HIGH;
                    else
                        n_pairs++;
                    cp         = SUPP_BASE + {1'b0, held_bits, unit[9:0]};
                    held_bits  = '0;
                    held_valid = 1'b0;
                end
            end
            else
            begin
                if (held_valid)
                    err = ERR_HIGH_DROPPED;
                held_bits  = '0;
                held_valid = 1'b0;
                cp         = {5'd0, unit};
            end

            // End of string drops the held high and restores the byte order
            if (eos)
            begin
                dang       = held_valid;
                held_bits  = '0;
                held_valid = 1'b0;
                order_big  = init_big;
            end

            // UTF-8 encoding
            if (cp == 21'd0)
            begin
                n = 0;
            end
            else if (cp < LIMIT_1B)
            begin
                n      = 1;
                enc[0] = cp[7:0];
            end
            else if (cp < LIMIT_2B)
            begin
                n      = 2;
                enc[0] = LEAD_2B | {3'd0, cp[10:6]};
                enc[1] = CONT_PREFIX | {2'd0, cp[5:0]};
            end
            else if (cp < LIMIT_3B)
            begin
                n      = 3;
                enc[0] = LEAD_3B | {4'd0, cp[15:12]};
                enc[1] = CONT_PREFIX | {2'd0, cp[11:6]};
                enc[2] = CONT_PREFIX | {2'd0, cp[5:0]};
            end
            else
            begin
                n      = 4;
                enc[0] = LEAD_4B | {5'd0, cp[20:18]};
                enc[1] = CONT_PREFIX | {2'd0, cp[17:12]};
                enc[2] = CONT_PREFIX | {2'd0, cp[11:6]};
                enc[3] = CONT_PREFIX | {2'd0, cp[5:0]};
            end

            err_seen[err]++;
            if (dang)
                n_dangling++;

            if (n == 0)
            begin
                n_empty++;
                r.utf8_byte       = 8'd0;
                r.byte_valid      = 1'b0;
                r.last_of_run     = 1'b1;
                r.unit_error      = err;
                r.dangling_at_end = dang;
                pending_bytes.push_back(r);
            end
            else
            begin
                for (k = 0; k < n; k++)
                begin
                    r.utf8_byte       = enc[k];
                    r.byte_valid      = 1'b1;
                    r.last_of_run     = (k == n - 1);
                    r.unit_error      = err;
                    r.dangling_at_end = dang;
                    pending_bytes.push_back(r);
                end
            end
        endfunction

        // Accepted output transfer: compare with the oldest expected byte
        function void check_byte(logic [7:0] data, logic last, logic [3:0] user);
            utf8_result_t exp_r;
            if (pending_bytes.size() == 0)
            begin
                $error("UTF-8 transfer with nothing expected: data %h last %b user %h",
                       data, last, user);
                errors++;
                return;
            end
            exp_r = pending_bytes.pop_front();
            n_results++;
            if (data !== exp_r.utf8_byte)
            begin
                $error("utf8_byte: expected %h, got %h", exp_r.utf8_byte, data);
                errors++;
            end
            if (user[0] !== exp_r.byte_valid)
            begin
                $error("byte_valid: expected %b, got %b", exp_r.byte_valid, user[0]);
                errors++;
            end
            if (last !== exp_r.last_of_run)
            begin
                $error("last_of_run: expected %b, got %b", exp_r.last_of_run, last);
                errors++;
            end
            if (user[2:1] !== exp_r.unit_error)
            begin
                $error("unit_error: expected %0d, got %0d", exp_r.unit_error, user[2:1]);
                errors++;
            end
            if (user[3] !== exp_r.dangling_at_end)
            begin
                $error("dangling_at_end: expected %b, got %b",
                       exp_r.dangling_at_end, user[3]);
                errors++;
            end
        endfunction
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic        cfg_wr_data   = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'd0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;
    logic [3:0]  m_axis_tuser;

    utf8_scoreboard sb;
    int          n_sent     = 0;
    int          burst_left = 0;
    bit          no_idle    = 1'b0;
    int          rx_mode    = 0;
    int          idle_count = 0;
    int          stall_pos  = 0;
    logic [15:0] stall_mask = 16'hFFFF;
    int          n_cfg_writes = 0;

    utf16_to_utf8_transcoder_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Clock
    always #4 clk = ~clk;

    // Receiver backpressure: full rate, rotating stall mask, or random stalls
    always @(posedge clk)
    begin
        if (stall_pos == 15)
        begin
            stall_mask = 16'($urandom);
            stall_mask[0] = 1'b1;
            stall_pos = 0;
        end
        else
        begin
            stall_pos = stall_pos + 1;
        end
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= stall_mask[stall_pos];
            default: m_axis_tready <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // Output monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_count = 0;
        else
            idle_count = idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles, %0d bytes still expected",
                     WATCHDOG_LIMIT, sb.outstanding());
            $display("DONE: errors detected");
            $finish;
        end
    end

    // One input transfer, with sender bursts and gaps
    task automatic send_item(input logic [7:0] b0, input logic [7:0] b1, input logic eos);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = no_idle ? 0 : $urandom_range(0, 5);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b1, b0};
        s_axis_tlast  <= eos;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_unit(b0, b1, eos);
        n_sent++;
    endtask

    // Send a 16-bit code unit in the byte order the block currently uses
    task automatic send_unit16(input logic [15:0] u, input logic eos);
        if (sb.order_big)
            send_item(u[15:8], u[7:0], eos);
        else
            send_item(u[7:0], u[15:8], eos);
    endtask

    // Wait for the block to go idle, then write the initial byte order
    task automatic write_initial_order(input bit big);
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= big;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.load_config(big);
        n_cfg_writes++;
        burst_left = 0;
    endtask

    // One string of mostly well-formed content with some noise
    task automatic send_random_string(input int len);
        int          i;
        int          kind;
        logic        eos;
        logic [15:0] u;
        logic [7:0]  r0;
        logic [7:0]  r1;
        for (i = 0; i < len; i++)
        begin
            eos  = (i == len - 1);
            kind = $urandom_range(0, 99);
            if (kind < 30)
            begin
                u = 16'($urandom_range(1, 16'h007F));
                send_unit16(u, eos);
            end
            else if (kind < 45)
            begin
                u = 16'($urandom_range(16'h0080, 16'h07FF));
                send_unit16(u, eos);
            end
            else if (kind < 60)
            begin
                u = 16'($urandom_range(16'h0800, 16'hFFFF));
                if ((u & SURR_MASK) == SURR_BASE)
                    u = u ^ 16'h2000;
                send_unit16(u, eos);
            end
            else if (kind < 80)
            begin
                // well-formed surrogate pair
                u = 16'($urandom_range(0, 1023));
                send_unit16(u | SURR_BASE, 1'b0);
                u = 16'($urandom_range(0, 1023));
                send_unit16(u | SURR_BASE | SURR_LOW_BIT, eos);
            end
            else if (kind < 84)
            begin
                if ($urandom_range(0, 1))
                    send_item(BOM_FE, BOM_FF, eos);
                else
                    send_item(BOM_FF, BOM_FE, eos);
            end
            else if (kind < 87)
            begin
                send_unit16(16'h0000, eos);
            end
            else if (kind < 91)
            begin
                // lone high surrogate
                u = 16'($urandom_range(0, 1023));
                send_unit16(u | SURR_BASE, eos);
            end
            else if (kind < 94)
            begin
                // lone low surrogate
                u = 16'($urandom_range(0, 1023));
                send_unit16(u | SURR_BASE | SURR_LOW_BIT, eos);
            end
            else
            begin
                r0 = 8'($urandom_range(0, 255));
                r1 = 8'($urandom_range(0, 255));
                send_item(r0, r1, eos);
            end
        end
    endtask

    task automatic run_random_strings(input int unit_target);
        int stop_at;
        stop_at = n_sent + unit_target;
        while (n_sent < stop_at)
            send_random_string($urandom_range(1, 10));
    endtask

    // Main sequence
    initial
    begin
        int p;
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset byte order (big endian)
        rx_mode = 1;
        send_item(8'h00, 8'h41, 1'b0);   // ASCII
        send_item(8'h00, 8'h00, 1'b0);   // zero code point, empty run
        send_item(8'h00, 8'h7F, 1'b0);   // top of one-byte range
        send_item(8'h00, 8'h80, 1'b0);   // bottom of two-byte range
        send_item(8'h07, 8'hFF, 1'b0);   // top of two-byte range
        send_item(8'h08, 8'h00, 1'b0);   // bottom of three-byte range
        send_item(8'hFF, 8'hFF, 1'b0);   // top of BMP
        send_item(8'hD8, 8'h00, 1'b0);   // lowest pair
        send_item(8'hDC, 8'h00, 1'b0);
        send_item(8'hDB, 8'hFF, 1'b0);   // highest pair
        send_item(8'hDF, 8'hFF, 1'b0);
        send_item(8'hD8, 8'h3D, 1'b0);   // high replaced by another high
        send_item(8'hD8, 8'h3D, 1'b0);
        send_item(8'hDE, 8'h00, 1'b0);
        send_item(8'hDC, 8'h00, 1'b0);   // low with nothing held
        send_item(8'hD8, 8'h00, 1'b0);   // held high dropped by a plain unit
        send_item(8'h00, 8'h41, 1'b0);
        send_item(8'hD8, 8'h01, 1'b1);   // string ends with a high held
        send_item(BOM_FF, BOM_FE, 1'b0); // switch to little endian
        send_item(8'h3D, 8'hD8, 1'b0);   // little endian pair
        send_item(8'h00, 8'hDE, 1'b0);
        send_item(8'h41, 8'h00, 1'b1);   // end of string restores byte order
        send_item(BOM_FE, BOM_FF, 1'b0); // explicit big endian mark
        send_item(8'hD7, 8'hFF, 1'b0);   // just below the surrogate range
        send_item(8'hE0, 8'h00, 1'b1);   // just above it

        // Random phases, alternating the initial byte order
        for (p = 0; p < 4; p++)
        begin
            write_initial_order(p % 2 == 1);
            rx_mode = p % 3;
            no_idle = (p == 1);
            run_random_strings(RANDOM_UNITS);
        end

        // Drain
        s_axis_tvalid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d code units, %0d UTF-8 transfers, %0d pairs, %0d empty runs,",
                 n_sent, sb.n_results, sb.n_pairs, sb.n_empty);
        $display("%0d cfg writes; flags: high after high %0d, lone low %0d, dropped %0d, dangling %0d",
                 n_cfg_writes, sb.err_seen[ERR_HIGH_AFTER_HIGH], sb.err_seen[ERR_LOW_NO_HIGH],
                 sb.err_seen[ERR_HIGH_DROPPED], sb.n_dangling);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
